FILE: sv/fmrb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register map of the FM register bank with timers.
package fmrb_pkg;

    localparam int SHADOW_DEPTH = 512;
    localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

    localparam int TIMER1_PRESCALE = 4;
    localparam int TIMER2_PRESCALE = 16;
    localparam int T1_CNT_W        = $clog2(256 * TIMER1_PRESCALE);
    localparam int T2_CNT_W        = $clog2(256 * TIMER2_PRESCALE);
    localparam int T1_LIM_W        = T1_CNT_W + 1;
    localparam int T2_LIM_W        = T2_CNT_W + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register map (full shadow addresses)
    localparam logic [7:0]        REG_MODE      = 8'h05;
    localparam logic [ADDR_W-1:0] ADDR_T1_LOAD  = 9'h002;
    localparam logic [ADDR_W-1:0] ADDR_T2_LOAD  = 9'h003;
    localparam logic [ADDR_W-1:0] ADDR_TCTRL    = 9'h004;
    localparam logic [ADDR_W-1:0] ADDR_MODE     = 9'h105;
    localparam logic [8:0]        TIMER_SPAN    = 9'h100;

    // Bit positions
    localparam int MODE_NEW_BIT    = 0;
    localparam int MODE_NEW2_BIT   = 1;
    localparam int TCTRL_RST_BIT   = 7;
    localparam int TCTRL_MASK1_BIT = 6;
    localparam int TCTRL_MASK2_BIT = 5;
    localparam int TCTRL_EN2_BIT   = 1;
    localparam int TCTRL_EN1_BIT   = 0;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              new_mode;
        logic              new2_mode;
    } entry_t;

endpackage

FILE: sv/fmrb_ifs.sv
`timescale 1ns / 1ps
// Command and response channel interfaces.
interface fmrb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       bank;
    logic [7:0] reg_req;
    logic [7:0] data;

    modport source (output valid, output op, output bank, output reg_req, output data,
                    input ready);
    modport sink   (input valid, input op, input bank, input reg_req, input data,
                    output ready);
endinterface

interface fmrb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timer1_flag;
    logic       timer2_flag;
    logic       new_mode;
    logic       new2_mode;

    modport source (output valid, output read_data, output timer1_flag,
                    output timer2_flag, output new_mode, output new2_mode,
                    input ready);
    modport sink   (input valid, input read_data, input timer1_flag,
                    input timer2_flag, input new_mode, input new2_mode,
                    output ready);
endinterface

FILE: sv/fmrb_front.sv
`timescale 1ns / 1ps
// Front end: accepts command items, resolves bank aliasing and tracks the mode bits.
module fmrb_front (
    input  logic              clk,
    input  logic              rst_n,
    fmrb_cmd_if.sink          cmd,
    input  logic              q_full,
    input  logic              clr_busy,
    output logic              push,
    output fmrb_pkg::entry_t  entry
);

    logic new_reg;
    logic new2_reg;
    logic alias_bank;
    logic mode_wr;

    assign cmd.ready = !q_full && !clr_busy;
    assign push      = cmd.valid && cmd.ready;

    always_comb
    begin
        // Bank 1 folds onto bank 0 until NEW is set, except the mode register
        alias_bank = cmd.bank && !new_reg && (cmd.reg_req != fmrb_pkg::REG_MODE);
        entry.op   = fmrb_pkg::op_t'(cmd.op);
        entry.addr = {cmd.bank && !alias_bank, cmd.reg_req};
        entry.data = cmd.data;
        mode_wr    = (entry.op == fmrb_pkg::OP_WRITE) && (entry.addr == fmrb_pkg::ADDR_MODE);
        entry.new_mode  = mode_wr ? cmd.data[fmrb_pkg::MODE_NEW_BIT]  : new_reg;
        entry.new2_mode = mode_wr ? cmd.data[fmrb_pkg::MODE_NEW2_BIT] : new2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_reg  <= 1'b0;
            new2_reg <= 1'b0;
        end
        else if (push)
        begin
            new_reg  <= entry.new_mode;
            new2_reg <= entry.new2_mode;
        end
    end

endmodule

FILE: sv/fmrb_queue.sv
`timescale 1ns / 1ps
// Short FIFO of decoded items between front and back end.
module fmrb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fmrb_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output fmrb_pkg::entry_t  head
);

    fmrb_pkg::entry_t                  slot_reg [fmrb_pkg::Q_DEPTH];
    logic [fmrb_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [fmrb_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [fmrb_pkg::Q_CNT_W-1:0]      count_reg;
    logic [fmrb_pkg::Q_PTR_W-1:0]      wr_ptr_next;
    logic [fmrb_pkg::Q_PTR_W-1:0]      rd_ptr_next;
    logic [fmrb_pkg::Q_CNT_W-1:0]      count_next;

    localparam logic [fmrb_pkg::Q_PTR_W-1:0] LAST_PTR = fmrb_pkg::Q_PTR_W'(fmrb_pkg::Q_DEPTH - 1);
    localparam logic [fmrb_pkg::Q_CNT_W-1:0] DEPTH_CNT = fmrb_pkg::Q_CNT_W'(fmrb_pkg::Q_DEPTH);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/fmrb_back.sv
`timescale 1ns / 1ps
// Back end: shadow memory with clearing pass, timers and the response register.
module fmrb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  fmrb_pkg::entry_t  head,
    output logic              pop,
    output logic              clr_busy,
    fmrb_rsp_if.source        rsp
);

    localparam int AW  = fmrb_pkg::ADDR_W;
    localparam int C1W = fmrb_pkg::T1_CNT_W;
    localparam int C2W = fmrb_pkg::T2_CNT_W;
    localparam int L1W = fmrb_pkg::T1_LIM_W;
    localparam int L2W = fmrb_pkg::T2_LIM_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(fmrb_pkg::SHADOW_DEPTH - 1);

    logic [7:0]     shadow_mem [fmrb_pkg::SHADOW_DEPTH];
    logic [7:0]     rd_data_reg;
    logic           rd_sel_reg;

    logic           clr_busy_reg;
    logic [AW-1:0]  clr_idx_reg;

    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    logic           new_mode_reg;
    logic           new2_mode_reg;

    logic [C1W-1:0] t1_count_reg;
    logic [C1W-1:0] t1_count_next;
    logic [C2W-1:0] t2_count_reg;
    logic [C2W-1:0] t2_count_next;
    logic [7:0]     t1_reload_reg;
    logic [7:0]     t1_reload_next;
    logic [7:0]     t2_reload_reg;
    logic [7:0]     t2_reload_next;
    logic [1:0]     enables_reg;
    logic [1:0]     enables_next;
    logic [1:0]     masks_reg;
    logic [1:0]     masks_next;
    logic [1:0]     flags_reg;
    logic [1:0]     flags_next;

    logic [8:0]     t1_span;
    logic [8:0]     t2_span;
    logic [L1W-1:0] t1_limit;
    logic [L2W-1:0] t2_limit;
    logic [L1W-1:0] t1_inc;
    logic [L2W-1:0] t2_inc;
    logic           is_write;
    logic           is_tick;

    assign clr_busy = clr_busy_reg;
    assign pop      = q_not_empty && !clr_busy_reg && (!rsp_valid_reg || rsp.ready);
    assign is_write = (head.op == fmrb_pkg::OP_WRITE);
    assign is_tick  = (head.op == fmrb_pkg::OP_TICK);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rd_sel_reg ? rd_data_reg : 8'h00;
    assign rsp.timer1_flag = flags_reg[0];
    assign rsp.timer2_flag = flags_reg[1];
    assign rsp.new_mode    = new_mode_reg;
    assign rsp.new2_mode   = new2_mode_reg;

    always_comb
    begin
        t1_span  = fmrb_pkg::TIMER_SPAN - {1'b0, t1_reload_reg};
        t2_span  = fmrb_pkg::TIMER_SPAN - {1'b0, t2_reload_reg};
        t1_limit = L1W'(t1_span) * L1W'(fmrb_pkg::TIMER1_PRESCALE);
        t2_limit = L2W'(t2_span) * L2W'(fmrb_pkg::TIMER2_PRESCALE);
        t1_inc   = {1'b0, t1_count_reg} + 1'b1;
        t2_inc   = {1'b0, t2_count_reg} + 1'b1;

        t1_count_next  = t1_count_reg;
        t2_count_next  = t2_count_reg;
        t1_reload_next = t1_reload_reg;
        t2_reload_next = t2_reload_reg;
        enables_next   = enables_reg;
        masks_next     = masks_reg;
        flags_next     = flags_reg;

        if (pop && is_tick)
        begin
            if (enables_reg[0])
            begin
                if (t1_inc >= t1_limit)
                begin
                    t1_count_next = '0;
                    if (!masks_reg[0])
                    begin
                        flags_next[0] = 1'b1;
                    end
                end
                else
                begin
                    t1_count_next = t1_inc[C1W-1:0];
                end
            end
            if (enables_reg[1])
            begin
                if (t2_inc >= t2_limit)
                begin
                    t2_count_next = '0;
                    if (!masks_reg[1])
                    begin
                        flags_next[1] = 1'b1;
                    end
                end
                else
                begin
                    t2_count_next = t2_inc[C2W-1:0];
                end
            end
        end
        else if (pop && is_write)
        begin
            case (head.addr)
                fmrb_pkg::ADDR_T1_LOAD: t1_reload_next = head.data;
                fmrb_pkg::ADDR_T2_LOAD: t2_reload_next = head.data;
                fmrb_pkg::ADDR_TCTRL:
                begin
                    // Flag reset leaves enables and masks alone
                    if (head.data[fmrb_pkg::TCTRL_RST_BIT])
                    begin
                        flags_next = 2'b00;
                    end
                    else
                    begin
                        enables_next = {head.data[fmrb_pkg::TCTRL_EN2_BIT],
                                        head.data[fmrb_pkg::TCTRL_EN1_BIT]};
                        masks_next   = {head.data[fmrb_pkg::TCTRL_MASK2_BIT],
                                        head.data[fmrb_pkg::TCTRL_MASK1_BIT]};
                    end
                end
                default: ;
            endcase
        end

        rsp_valid_next = rsp_valid_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            new_mode_reg  <= 1'b0;
            new2_mode_reg <= 1'b0;
            rd_sel_reg    <= 1'b0;
            t1_count_reg  <= '0;
            t2_count_reg  <= '0;
            t1_reload_reg <= '0;
            t2_reload_reg <= '0;
            enables_reg   <= '0;
            masks_reg     <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            rsp_valid_reg <= rsp_valid_next;
            if (pop)
            begin
                new_mode_reg  <= head.new_mode;
                new2_mode_reg <= head.new2_mode;
                rd_sel_reg    <= (head.op == fmrb_pkg::OP_READ);
            end
            t1_count_reg  <= t1_count_next;
            t2_count_reg  <= t2_count_next;
            t1_reload_reg <= t1_reload_next;
            t2_reload_reg <= t2_reload_next;
            enables_reg   <= enables_next;
            masks_reg     <= masks_next;
            flags_reg     <= flags_next;
        end
    end

    // Shadow memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            shadow_mem[clr_idx_reg] <= 8'h00;
        end
        else if (pop && is_write)
        begin
            shadow_mem[head.addr] <= head.data;
        end
        if (pop)
        begin
            rd_data_reg <= shadow_mem[head.addr];
        end
    end

endmodule

FILE: sv/fm_register_bank_with_timers.sv
`timescale 1ns / 1ps
// Response path: an accepted command goes into a queue slot, then through the memory/timer
// stage, whose response register drives response valid.
// Throughput: one item per cycle through the memory/timer stage, unless the receiver stalls.
// The response register holds a stalled result while the front keeps filling a 2-entry queue.
// Reset: asynchronous, active low; timers, flags and mode bits clear at once.
// After reset a pass zeroes all 512 shadow memory entries; no command is taken until it ends.
module fm_register_bank_with_timers (
    input  logic        clk,
    input  logic        rst_n,
    fmrb_cmd_if.sink    cmd,
    fmrb_rsp_if.source  rsp
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_not_empty;
    logic              clr_busy;
    fmrb_pkg::entry_t  push_entry;
    fmrb_pkg::entry_t  head;

    fmrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_full   (q_full),
        .clr_busy (clr_busy),
        .push     (push),
        .entry    (push_entry)
    );

    fmrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    fmrb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .clr_busy    (clr_busy),
        .rsp         (rsp)
    );

endmodule

FILE: dv/fm_register_bank_with_timers_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FM register bank with interval timers.
module fm_register_bank_with_timers_test;

    typedef struct packed {
        fmrb_pkg::op_t op;
        logic          bank;
        logic [7:0]    reg_idx;
        logic [7:0]    data;
    } bus_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer1_flag;
        logic       timer2_flag;
        logic       new_mode;
        logic       new2_mode;
    } bank_status_t;

    typedef struct packed {
        bus_cmd_t     cmd;
        logic         fixed;
        bank_status_t status;
    } script_row_t;

    localparam int SCRIPT_LEN     = 25;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int BLOCK_ITEMS    = 50;
    localparam int BLOCK_COUNT    = RANDOM_ITEMS / BLOCK_ITEMS;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] T1_IDX    = fmrb_pkg::ADDR_T1_LOAD[7:0];
    localparam logic [7:0] T2_IDX    = fmrb_pkg::ADDR_T2_LOAD[7:0];
    localparam logic [7:0] TCTRL_IDX = fmrb_pkg::ADDR_TCTRL[7:0];
    localparam logic [7:0] MODE_IDX  = fmrb_pkg::REG_MODE;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fmrb_cmd_if cmd_if ();
    fmrb_rsp_if rsp_if ();

    fm_register_bank_with_timers i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    // Shadow copy of the block's state
    logic [7:0]                    shadow_q [fmrb_pkg::SHADOW_DEPTH] = '{default: '0};
    logic [fmrb_pkg::T1_CNT_W-1:0] t1_cnt   = '0;
    logic [fmrb_pkg::T2_CNT_W-1:0] t2_cnt   = '0;
    logic [7:0]                    t1_load  = '0;
    logic [7:0]                    t2_load  = '0;
    logic [1:0]                    tmr_en   = '0;
    logic [1:0]                    tmr_mask = '0;
    logic [1:0]                    tmr_flag = '0;
    logic [1:0]                    mode_q   = '0;

    bank_status_t pending_status [$];
    int  error_count  = 0;
    int  quiet_cycles = 0;
    int  gap_pct      = 0;
    bit  hold_req     = 1'b0;
    int  n_read, n_write, n_tick, n_nop;
    int  t1_seen, t2_seen;

    // Directed steps; rows marked fixed carry their expected status
    script_row_t script [SCRIPT_LEN] = '{
        '{'{fmrb_pkg::OP_READ,  1'b0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_READ,  1'b1, 8'hFF, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_WRITE, 1'b0, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{fmrb_pkg::OP_READ,  1'b1, 8'hFF, 8'h00}, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_WRITE, 1'b0, T1_IDX, 8'hFE}, 1'b0, '0},
        '{'{fmrb_pkg::OP_WRITE, 1'b0, TCTRL_IDX, 8'h01}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b1, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        // shrink the limit below the running count
        '{'{fmrb_pkg::OP_WRITE, 1'b0, T1_IDX, 8'hFF}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_WRITE, 1'b0, TCTRL_IDX, 8'h80}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_NOP,   1'b1, 8'h55, 8'hAA}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_WRITE, 1'b1, TCTRL_IDX, 8'h62}, 1'b0, '0},
        '{'{fmrb_pkg::OP_WRITE, 1'b1, MODE_IDX, 8'h03}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{fmrb_pkg::OP_WRITE, 1'b1, T1_IDX, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_READ,  1'b0, T1_IDX, 8'h00}, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{fmrb_pkg::OP_READ,  1'b1, T1_IDX, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{fmrb_pkg::OP_WRITE, 1'b0, TCTRL_IDX, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_TICK,  1'b0, 8'h00, 8'h00}, 1'b0, '0},
        '{'{fmrb_pkg::OP_WRITE, 1'b1, MODE_IDX, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{fmrb_pkg::OP_WRITE, 1'b1, T2_IDX, 8'hFF}, 1'b0, '0}
    };

    function automatic bank_status_t apply_bus_cmd(bus_cmd_t c);
        bank_status_t                s;
        logic [fmrb_pkg::ADDR_W-1:0] addr;
        int                          nxt;
        s = '0;
        // bank 1 folds onto bank 0 until NEW is set, except the mode register
        if (c.bank && !mode_q[fmrb_pkg::MODE_NEW_BIT] && c.reg_idx != fmrb_pkg::REG_MODE)
            addr = {1'b0, c.reg_idx};
        else
            addr = {c.bank, c.reg_idx};
        case (c.op)
            fmrb_pkg::OP_READ:
            begin
                s.read_data = shadow_q[addr];
            end
            fmrb_pkg::OP_WRITE:
            begin
                shadow_q[addr] = c.data;
                if (addr == fmrb_pkg::ADDR_T1_LOAD)
                    t1_load = c.data;
                else if (addr == fmrb_pkg::ADDR_T2_LOAD)
                    t2_load = c.data;
                else if (addr == fmrb_pkg::ADDR_TCTRL)
                begin
                    if (c.data[fmrb_pkg::TCTRL_RST_BIT])
                        tmr_flag = '0;
                    else
                    begin
                        tmr_en   = {c.data[fmrb_pkg::TCTRL_EN2_BIT],
                                    c.data[fmrb_pkg::TCTRL_EN1_BIT]};
                        tmr_mask = {c.data[fmrb_pkg::TCTRL_MASK2_BIT],
                                    c.data[fmrb_pkg::TCTRL_MASK1_BIT]};
                    end
                end
                else if (addr == fmrb_pkg::ADDR_MODE)
                    mode_q = {c.data[fmrb_pkg::MODE_NEW2_BIT], c.data[fmrb_pkg::MODE_NEW_BIT]};
            end
            fmrb_pkg::OP_TICK:
            begin
                if (tmr_en[0])
                begin
                    nxt = int'(t1_cnt) + 1;
                    if (nxt >= (int'(fmrb_pkg::TIMER_SPAN) - int'(t1_load)) *
                               fmrb_pkg::TIMER1_PRESCALE)
                    begin
                        t1_cnt = '0;
                        if (!tmr_mask[0])
                            tmr_flag[0] = 1'b1;
                    end
                    else
                        t1_cnt = nxt[fmrb_pkg::T1_CNT_W-1:0];
                end
                if (tmr_en[1])
                begin
                    nxt = int'(t2_cnt) + 1;
                    if (nxt >= (int'(fmrb_pkg::TIMER_SPAN) - int'(t2_load)) *
                               fmrb_pkg::TIMER2_PRESCALE)
                    begin
                        t2_cnt = '0;
                        if (!tmr_mask[1])
                            tmr_flag[1] = 1'b1;
                    end
                    else
                        t2_cnt = nxt[fmrb_pkg::T2_CNT_W-1:0];
                end
            end
            default: ;
        endcase
        s.timer1_flag = tmr_flag[0];
        s.timer2_flag = tmr_flag[1];
        s.new_mode    = mode_q[fmrb_pkg::MODE_NEW_BIT];
        s.new2_mode   = mode_q[fmrb_pkg::MODE_NEW2_BIT];
        return s;
    endfunction

    // Mostly timer traffic with short limits, so flags rise often
    function automatic bus_cmd_t make_random_cmd();
        bus_cmd_t c;
        int       pick;
        c.op      = fmrb_pkg::OP_WRITE;
        c.bank    = 1'($urandom_range(0, 1));
        c.reg_idx = 8'($urandom);
        c.data    = 8'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 35)
            c.op = fmrb_pkg::OP_TICK;
        else if (pick < 45)
        begin
            c.reg_idx = $urandom_range(0, 1) ? T1_IDX : T2_IDX;
            if ($urandom_range(0, 3) != 0)
            begin
                c.bank = 1'b0;
                c.data = 8'($urandom_range(8'hF0, 8'hFF));
            end
        end
        else if (pick < 55)
        begin
            c.reg_idx = TCTRL_IDX;
            if ($urandom_range(0, 3) != 0)
                c.bank = 1'b0;
            if ($urandom_range(0, 4) == 0)
                c.data[fmrb_pkg::TCTRL_RST_BIT] = 1'b1;
            else
            begin
                c.data[fmrb_pkg::TCTRL_RST_BIT] = 1'b0;
                if ($urandom_range(0, 3) != 0)
                begin
                    c.data[fmrb_pkg::TCTRL_EN1_BIT] = 1'b1;
                    c.data[fmrb_pkg::TCTRL_EN2_BIT] = 1'b1;
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    c.data[fmrb_pkg::TCTRL_MASK1_BIT] = 1'b0;
                    c.data[fmrb_pkg::TCTRL_MASK2_BIT] = 1'b0;
                end
            end
        end
        else if (pick < 60)
        begin
            c.bank    = 1'b1;
            c.reg_idx = MODE_IDX;
        end
        else if (pick < 75)
            c.op = fmrb_pkg::OP_WRITE;
        else if (pick < 93)
        begin
            c.op = fmrb_pkg::OP_READ;
            if ($urandom_range(0, 1) != 0)
                c.reg_idx = 8'($urandom_range(0, 7));
        end
        else
            c.op = fmrb_pkg::OP_NOP;
        return c;
    endfunction

    task automatic send_cmd(bus_cmd_t c, logic fixed, bank_status_t want);
        bank_status_t pred;
        cmd_if.valid   <= 1'b1;
        cmd_if.op      <= c.op;
        cmd_if.bank    <= c.bank;
        cmd_if.reg_req <= c.reg_idx;
        cmd_if.data    <= c.data;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        pred = apply_bus_cmd(c);
        pending_status.push_back(fixed ? want : pred);
        case (c.op)
            fmrb_pkg::OP_READ:  n_read++;
            fmrb_pkg::OP_WRITE: n_write++;
            fmrb_pkg::OP_TICK:  n_tick++;
            default:            n_nop++;
        endcase
    endtask

    task automatic sender_gap();
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd_if.valid   <= 1'b0;
            cmd_if.op      <= fmrb_pkg::op_t'($urandom_range(0, 3));
            cmd_if.bank    <= 1'($urandom);
            cmd_if.reg_req <= 8'($urandom);
            cmd_if.data    <= 8'($urandom);
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin : stimulus
        int blk;
        cmd_if.valid   = 1'b0;
        cmd_if.op      = fmrb_pkg::OP_NOP;
        cmd_if.bank    = 1'b0;
        cmd_if.reg_req = '0;
        cmd_if.data    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 20;
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (i != 0)
                sender_gap();
            send_cmd(script[i].cmd, script[i].fixed, script[i].status);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % BLOCK_ITEMS == 0)
            begin
                blk = i / BLOCK_ITEMS;
                if (blk >= BLOCK_COUNT - 4)
                    gap_pct = 0;
                else
                    case (blk % 4)
                        0:       gap_pct = 0;
                        1:       gap_pct = 10;
                        2:       gap_pct = 45;
                        default: gap_pct = 25;
                    endcase
                // back-pressure: keep offering while the receiver holds off
                if (blk == 5)
                begin
                    gap_pct  = 0;
                    hold_req = 1'b1;
                end
            end
            if (i % BLOCK_ITEMS == 0 && i / BLOCK_ITEMS == 11)
            begin
                // drain everything before going on
                cmd_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_status.size() != 0);
            end
            else
                sender_gap();
            send_cmd(make_random_cmd(), 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items: %0d reads, %0d writes, %0d ticks, %0d unused-op items.",
                 n_read + n_write + n_tick + n_nop, n_read, n_write, n_tick, n_nop);
        $display("Results with timer 1 flag set: %0d, with timer 2 flag set: %0d.",
                 t1_seen, t2_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : response_pacing
        rsp_if.ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : response_check
        bank_status_t got;
        bank_status_t want;
        if (rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.read_data, rsp_if.timer1_flag, rsp_if.timer2_flag,
                    rsp_if.new_mode, rsp_if.new2_mode};
            t1_seen += got.timer1_flag;
            t2_seen += got.timer2_flag;
            if (pending_status.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result with none expected, expected none, actual %p",
                         $time, got);
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("timer1_flag", 8'(want.timer1_flag), 8'(got.timer1_flag));
                check_field("timer2_flag", 8'(want.timer2_flag), 8'(got.timer2_flag));
                check_field("new_mode", 8'(want.new_mode), 8'(got.new_mode));
                check_field("new2_mode", 8'(want.new2_mode), 8'(got.new2_mode));
            end
        end
    end

    // Covers the clearing pass after reset and the long receiver hold
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no traffic for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_status.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
